// File: hdl/rrfc_pkg.sv
// Shared types and constants for the RTU reply frame checker.
package rrfc_pkg;

  localparam int LEN_W  = 9;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 16;

  localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

  localparam logic OP_DATA = 1'b0;
  localparam logic OP_GAP  = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [LEN_W-1:0]  len_t;

  typedef struct packed {
    logic  operation;
    byte_t data_byte;
    byte_t expected_address;
    logic  awaiting_reply;
  } req_t;

  typedef struct packed {
    logic  accepted;
    logic  crc_good;
    logic  overrun;
    logic  address_match;
    len_t  frame_length;
    byte_t slave_address;
  } rsp_t;

endpackage

// File: hdl/rrfc_in_if.sv
// Request channel carrying received bytes and frame-gap events.
interface rrfc_in_if;
  logic                valid;
  logic                ready;
  logic                operation;
  rrfc_pkg::byte_t     data_byte;
  rrfc_pkg::byte_t     expected_address;
  logic                awaiting_reply;

  modport source (output valid, operation, data_byte, expected_address, awaiting_reply,
                  input ready);
  modport sink   (input valid, operation, data_byte, expected_address, awaiting_reply,
                  output ready);
endinterface

// File: hdl/rrfc_out_if.sv
// Result channel carrying the frame verdict.
interface rrfc_out_if;
  logic                valid;
  logic                ready;
  logic                accepted;
  logic                crc_good;
  logic                overrun;
  logic                address_match;
  rrfc_pkg::len_t      frame_length;
  rrfc_pkg::byte_t     slave_address;

  modport source (output valid, accepted, crc_good, overrun, address_match, frame_length,
                  slave_address, input ready);
  modport sink   (input valid, accepted, crc_good, overrun, address_match, frame_length,
                  slave_address, output ready);
endinterface

// File: hdl/rrfc_crc_byte.sv
// One-byte update of the reflected CRC-16 (poly 0xA001).
module rrfc_crc_byte (
  input  rrfc_pkg::crc_t  crc_i,
  input  rrfc_pkg::byte_t byte_i,
  output rrfc_pkg::crc_t  crc_o
);

  always_comb begin
    rrfc_pkg::crc_t c;
    c = crc_i ^ {{(rrfc_pkg::CRC_W-rrfc_pkg::BYTE_W){1'b0}}, byte_i};
    for (int k = 0; k < rrfc_pkg::BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ rrfc_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: hdl/rtu_reply_frame_checker_core.sv
// Top level: Modbus RTU reply frame checker with CRC-16, address and overrun checks.
// A gap request passes the input register; its verdict is then held in the result register.
// Throughput: one request per cycle; the input register holds one request and the
// result register one verdict, so only a stalled result slot holds back the input.
// Reset (rst_n low, synchronous): clears valids, byte count, CRC to 0xFFFF and
// the recent-byte history; no clearing pass, the block is ready in the next cycle.
module rtu_reply_frame_checker_core #(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  rrfc_in_if.sink    in_req,
  rrfc_out_if.source out_rsp
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  // input register
  logic            stg_vld_r;
  rrfc_pkg::req_t  stg_r;
  logic            stg_go;

  // frame state
  rrfc_pkg::crc_t  crc_r, crc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  rrfc_pkg::byte_t rb0_r, rb1_r, rb2_r, rb0_nxt, rb1_nxt, rb2_nxt;
  rrfc_pkg::byte_t first_r, first_nxt;
  logic            ovr_r, ovr_nxt;

  // result register
  logic            out_vld_r, out_vld_nxt;
  rrfc_pkg::rsp_t  out_r, rsp;
  logic            emit;

  rrfc_pkg::crc_t  crc_fed;
  rrfc_pkg::len_t  len_full, len;
  logic            crc_ok;
  logic            slot_free;

  rrfc_crc_byte u_crc (
    .crc_i  (crc_r),
    .byte_i (rb2_r),
    .crc_o  (crc_fed)
  );

  assign slot_free    = !out_vld_r || out_rsp.ready;
  assign stg_go       = stg_vld_r && slot_free;
  assign in_req.ready = !stg_vld_r || stg_go;

  assign emit     = stg_go && (stg_r.operation == rrfc_pkg::OP_GAP) && (cnt_r != '0);
  assign len_full = rrfc_pkg::LEN_W'(cnt_r);

  always_comb begin
    len    = len_full;
    crc_ok = 1'b0;
    if (rb0_r == '0) begin
      len = len_full - rrfc_pkg::len_t'(1);
      if (len >= rrfc_pkg::len_t'(2)) begin
        crc_ok = (crc_r[7:0] == rb2_r) && (crc_r[15:8] == rb1_r);
      end
    end else if (len_full >= rrfc_pkg::len_t'(3)) begin
      crc_ok = (crc_fed[7:0] == rb1_r) && (crc_fed[15:8] == rb0_r);
    end else if (len_full == rrfc_pkg::len_t'(2)) begin
      crc_ok = (crc_r[7:0] == rb1_r) && (crc_r[15:8] == rb0_r);
    end

    rsp               = '0;
    rsp.crc_good      = crc_ok;
    rsp.overrun       = ovr_r;
    rsp.frame_length  = len;
    if (len != '0) begin
      rsp.slave_address = first_r;
      rsp.address_match = (first_r == stg_r.expected_address);
    end
    rsp.accepted = !ovr_r && crc_ok && rsp.address_match && stg_r.awaiting_reply;
  end

  always_comb begin
    crc_nxt   = crc_r;
    cnt_nxt   = cnt_r;
    rb0_nxt   = rb0_r;
    rb1_nxt   = rb1_r;
    rb2_nxt   = rb2_r;
    first_nxt = first_r;
    ovr_nxt   = ovr_r;
    if (stg_go) begin
      if (stg_r.operation == rrfc_pkg::OP_DATA) begin
        if (cnt_r < CNT_W'(MAX_FRAME)) begin
          if (cnt_r >= CNT_W'(3)) begin
            crc_nxt = crc_fed;
          end
          if (cnt_r == '0) begin
            first_nxt = stg_r.data_byte;
          end
          rb2_nxt = rb1_r;
          rb1_nxt = rb0_r;
          rb0_nxt = stg_r.data_byte;
          cnt_nxt = cnt_r + CNT_W'(1);
        end else begin
          ovr_nxt = 1'b1;
        end
      end else if (emit) begin
        crc_nxt   = rrfc_pkg::CRC_INIT;
        cnt_nxt   = '0;
        rb0_nxt   = '0;
        rb1_nxt   = '0;
        rb2_nxt   = '0;
        first_nxt = '0;
        ovr_nxt   = 1'b0;
      end
    end
    out_vld_nxt = emit || (out_vld_r && !out_rsp.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      crc_r     <= rrfc_pkg::CRC_INIT;
      cnt_r     <= '0;
      rb0_r     <= '0;
      rb1_r     <= '0;
      rb2_r     <= '0;
      first_r   <= '0;
      ovr_r     <= 1'b0;
    end else begin
      if (in_req.ready) begin
        stg_vld_r <= in_req.valid;
      end
      out_vld_r <= out_vld_nxt;
      crc_r     <= crc_nxt;
      cnt_r     <= cnt_nxt;
      rb0_r     <= rb0_nxt;
      rb1_r     <= rb1_nxt;
      rb2_r     <= rb2_nxt;
      first_r   <= first_nxt;
      ovr_r     <= ovr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      stg_r.operation        <= in_req.operation;
      stg_r.data_byte        <= in_req.data_byte;
      stg_r.expected_address <= in_req.expected_address;
      stg_r.awaiting_reply   <= in_req.awaiting_reply;
    end
    if (emit) begin
      out_r <= rsp;
    end
  end

  assign out_rsp.valid         = out_vld_r;
  assign out_rsp.accepted      = out_r.accepted;
  assign out_rsp.crc_good      = out_r.crc_good;
  assign out_rsp.overrun       = out_r.overrun;
  assign out_rsp.address_match = out_r.address_match;
  assign out_rsp.frame_length  = out_r.frame_length;
  assign out_rsp.slave_address = out_r.slave_address;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_FRAME))
    else $error("byte count above frame store size");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (cnt_r == '0) && !ovr_r && (crc_r == rrfc_pkg::CRC_INIT))
    else $error("frame state not cleared after verdict");

  a_verdict_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.accepted) |-> (out_r.crc_good && out_r.address_match && !out_r.overrun))
    else $error("accepted without all checks passing");

  a_crc_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.crc_good) |-> (out_r.frame_length >= rrfc_pkg::len_t'(2)))
    else $error("crc good on a frame shorter than two bytes");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_vld_r || out_rsp.ready))
    else $error("verdict written over an untaken result");

endmodule

// File: tb/rtu_reply_frame_checker_core_test.sv
// Self-checking testbench for the RTU reply frame checker: random and directed frames.
module rtu_reply_frame_checker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_MAX   = 256;
  localparam int ITEMS       = 1300;
  localparam int HOLD_CYCLES = 120;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rrfc_in_if  in_req ();
  rrfc_out_if out_rsp ();

  rtu_reply_frame_checker_core #(.MAX_FRAME(FRAME_MAX)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #5 clk = ~clk;

  // frame tracking state of the checker
  rrfc_pkg::crc_t  fr_crc;
  rrfc_pkg::len_t  fr_cnt;
  rrfc_pkg::byte_t fr_hist [3];
  rrfc_pkg::byte_t fr_first;
  logic            fr_ovf;

  rrfc_pkg::req_t requests_pending [$];
  rrfc_pkg::rsp_t verdicts_due [$];
  rrfc_pkg::req_t cur_req;
  int   n_sent = 0;
  int   n_total = 1;
  int   n_err = 0;
  bit   hold_off = 1'b0;

  int sender_idle_pct [4] = '{0, 57, 0, 26};
  int stall_pct [4]       = '{0, 0, 57, 26};

  function automatic rrfc_pkg::crc_t crc_byte(rrfc_pkg::crc_t c, rrfc_pkg::byte_t b);
    int k;
    c = c ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ rrfc_pkg::CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_frame();
    fr_crc   = rrfc_pkg::CRC_INIT;
    fr_cnt   = '0;
    fr_hist  = '{8'h00, 8'h00, 8'h00};
    fr_first = '0;
    fr_ovf   = 1'b0;
  endfunction

  // returns 1 when the request yields a verdict
  function automatic bit frame_verdict(input rrfc_pkg::req_t r, output rrfc_pkg::rsp_t v);
    rrfc_pkg::len_t n;
    rrfc_pkg::crc_t c;
    logic ok;
    v = '0;
    if (r.operation == rrfc_pkg::OP_DATA) begin
      if (fr_cnt < FRAME_MAX) begin
        if (fr_cnt >= 3) fr_crc = crc_byte(fr_crc, fr_hist[2]);
        if (fr_cnt == 0) fr_first = r.data_byte;
        fr_hist[2] = fr_hist[1];
        fr_hist[1] = fr_hist[0];
        fr_hist[0] = r.data_byte;
        fr_cnt = fr_cnt + 1'b1;
      end else begin
        fr_ovf = 1'b1;
      end
      return 1'b0;
    end
    if (fr_cnt == 0) return 1'b0;
    n  = fr_cnt;
    c  = fr_crc;
    ok = 1'b0;
    if (fr_hist[0] == 8'h00) begin
      n = n - 1'b1;
      if (n >= 2) ok = (c[7:0] == fr_hist[2]) && (c[15:8] == fr_hist[1]);
    end else if (n >= 2) begin
      if (n >= 3) c = crc_byte(c, fr_hist[2]);
      ok = (c[7:0] == fr_hist[1]) && (c[15:8] == fr_hist[0]);
    end
    v.crc_good     = ok;
    v.overrun      = fr_ovf;
    v.frame_length = n;
    if (n >= 1) begin
      v.slave_address = fr_first;
      v.address_match = (fr_first == r.expected_address);
    end
    v.accepted = !fr_ovf && ok && v.address_match && r.awaiting_reply;
    clear_frame();
    return 1'b1;
  endfunction

  function automatic int phase_now();
    int p;
    p = (n_sent * 4) / n_total;
    return (p > 3) ? 3 : p;
  endfunction

  task automatic put(logic op, rrfc_pkg::byte_t d, rrfc_pkg::byte_t a, logic aw);
    rrfc_pkg::req_t r;
    r.operation        = op;
    r.data_byte        = d;
    r.expected_address = a;
    r.awaiting_reply   = aw;
    requests_pending.push_back(r);
  endtask

  task automatic put_byte(rrfc_pkg::byte_t d);
    put(rrfc_pkg::OP_DATA, d, rrfc_pkg::byte_t'($urandom_range(255)),
        logic'($urandom_range(1)));
  endtask

  task automatic put_gap(rrfc_pkg::byte_t a, logic aw);
    put(rrfc_pkg::OP_GAP, rrfc_pkg::byte_t'($urandom_range(255)), a, aw);
  endtask

  task automatic put_frame(rrfc_pkg::byte_t addr, int n_pay, bit crc_ok, bit zero_tail,
                           rrfc_pkg::byte_t exp_addr, logic aw);
    rrfc_pkg::crc_t  c;
    rrfc_pkg::byte_t b;
    int              i;
    c = crc_byte(rrfc_pkg::CRC_INIT, addr);
    put_byte(addr);
    for (i = 0; i < n_pay; i++) begin
      b = rrfc_pkg::byte_t'($urandom_range(255));
      c = crc_byte(c, b);
      put_byte(b);
    end
    if (!crc_ok) c[7:0] = c[7:0] ^ rrfc_pkg::byte_t'($urandom_range(1, 255));
    put_byte(c[7:0]);
    put_byte(c[15:8]);
    if (zero_tail) put_byte(8'h00);
    put_gap(exp_addr, aw);
  endtask

  task automatic show_mismatch(string what, rrfc_pkg::rsp_t want, rrfc_pkg::rsp_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("%s: want acc=%0b crc=%0b ovr=%0b adr=%0b len=%0d slave=%02h", what,
               want.accepted, want.crc_good, want.overrun, want.address_match,
               want.frame_length, want.slave_address);
      $display("  got  acc=%0b crc=%0b ovr=%0b adr=%0b len=%0d slave=%02h",
               got.accepted, got.crc_good, got.overrun, got.address_match,
               got.frame_length, got.slave_address);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    rrfc_pkg::rsp_t v;
    if (!rst_n) begin
      in_req.valid <= 1'b0;
    end else if (!in_req.valid || in_req.ready) begin
      if (in_req.valid) begin
        if (frame_verdict(cur_req, v)) verdicts_due.push_back(v);
        n_sent <= n_sent + 1;
      end
      if (requests_pending.size() > 0 &&
          $urandom_range(99) >= sender_idle_pct[phase_now()]) begin
        cur_req = requests_pending.pop_front();
        in_req.operation        <= cur_req.operation;
        in_req.data_byte        <= cur_req.data_byte;
        in_req.expected_address <= cur_req.expected_address;
        in_req.awaiting_reply   <= cur_req.awaiting_reply;
        in_req.valid            <= 1'b1;
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin
    rrfc_pkg::rsp_t got;
    rrfc_pkg::rsp_t want;
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else begin
      if (out_rsp.valid && out_rsp.ready) begin
        got = '{out_rsp.accepted, out_rsp.crc_good, out_rsp.overrun,
                out_rsp.address_match, out_rsp.frame_length, out_rsp.slave_address};
        if (verdicts_due.size() == 0) begin
          show_mismatch("unexpected verdict", '0, got);
        end else begin
          want = verdicts_due.pop_front();
          if (got !== want) show_mismatch("verdict mismatch", want, got);
        end
      end
      out_rsp.ready <= !hold_off && ($urandom_range(99) >= stall_pct[phase_now()]);
    end
  end

  // long receiver hold-off while requests keep coming
  initial begin
    wait (rst_n === 1'b1);
    wait (n_sent >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int              frames;
    int              kind;
    int              i;
    int              n;
    rrfc_pkg::byte_t addr;
    clear_frame();

    // directed: empty gap, short frames, dropped zero, extremes
    put_gap(8'h00, 1'b0);
    put_byte(8'hFF);
    put_gap(8'hFF, 1'b1);
    put_byte(8'h00);
    put_gap(8'h00, 1'b1);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_gap(8'hFF, 1'b1);
    put_byte(8'hAB);
    put_byte(8'h00);
    put_gap(8'hAB, 1'b1);
    put_frame(8'h00, 0, 1'b1, 1'b1, 8'h00, 1'b1);
    put_frame(8'hFF, 2, 1'b1, 1'b0, 8'hFF, 1'b0);
    put_frame(8'h11, 1, 1'b0, 1'b0, 8'h12, 1'b1);

    frames = 0;
    while (requests_pending.size() < ITEMS) begin
      frames++;
      addr = rrfc_pkg::byte_t'($urandom_range(255));
      kind = $urandom_range(99);
      if (frames == 30) begin
        put_frame(addr, FRAME_MAX - 3, 1'b1, 1'b0, addr, 1'b1);
      end else if (frames == 70) begin
        put_frame(addr, FRAME_MAX + 41, 1'b1, 1'(($urandom_range(1))), addr, 1'b1);
      end else if (kind < 75) begin
        put_frame(addr, $urandom_range(12), $urandom_range(9) != 0, $urandom_range(3) == 0,
                  ($urandom_range(9) != 0) ? addr : rrfc_pkg::byte_t'($urandom_range(255)),
                  logic'($urandom_range(9) != 0));
      end else if (kind < 92) begin
        n = $urandom_range(6);
        for (i = 0; i < n; i++) begin
          put_byte(($urandom_range(3) == 0) ? 8'h00
                                            : rrfc_pkg::byte_t'($urandom_range(255)));
        end
        put_gap(rrfc_pkg::byte_t'($urandom_range(255)), logic'($urandom_range(1)));
      end else begin
        put_gap(rrfc_pkg::byte_t'($urandom_range(255)), logic'($urandom_range(1)));
      end
    end
    n_total = requests_pending.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == n_total);
    wait (verdicts_due.size() == 0);
    repeat (8) @(posedge clk);
    n_err += verdicts_due.size();
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/rrfc_pkg.sv
hdl/rrfc_in_if.sv
hdl/rrfc_out_if.sv
hdl/rrfc_crc_byte.sv
hdl/rtu_reply_frame_checker_core.sv
tb/rtu_reply_frame_checker_core_test.sv
